// ----- hdl/assert_macros.svh -----
// Assertion helpers, clocked on the rising edge and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bsc_pkg.sv -----
package bsc_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int MAX_RES    = 8;
    localparam int COUNT_BITS = 16;

    localparam int PROC_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int RES_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int ADDR_W  = PROC_W + RES_W;
    localparam int DEPTH   = MAX_PROCS * MAX_RES;
    localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
    localparam int RCNT_W  = $clog2(MAX_RES + 1);
    localparam int NEED_W  = COUNT_BITS + 1;
    localparam int WORK_W  = COUNT_BITS + $clog2(MAX_PROCS + 1);

    localparam int NUMP_W     = 5;
    localparam int NUMR_W     = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RES   = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD_ENTRY = 2'd0,
        REQ_LOAD_AVAIL = 2'd1,
        REQ_RUN        = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_READ,
        S_CMP,
        S_ADD,
        S_NEXT,
        S_DONE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr_entry;
        logic wr_avail;
        logic init;
        logic start_proc;
        logic cmp;
        logic add;
        logic next_proc;
        logic load_out;
        logic adv_out;
    } t_cmd;

    typedef struct packed {
        logic fin_cur;
        logic res_last;
        logic sweep_last;
        logic out_last;
    } t_stat;

endpackage

// ----- hdl/bsc_ctrl.sv -----
module bsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_req_type,
    input  logic                i_out_stall,
    input  bsc_pkg::t_stat      i_stat,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bsc_pkg::t_cmd       o_cmd
);

    bsc_pkg::t_state r_state;
    bsc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsc_pkg::S_IDLE: begin
                if (i_in_valid && bsc_pkg::t_req'(i_req_type) == bsc_pkg::REQ_RUN) begin
                    n_state = bsc_pkg::S_PROC;
                end
            end
            bsc_pkg::S_PROC: begin
                n_state = i_stat.fin_cur ? bsc_pkg::S_NEXT : bsc_pkg::S_READ;
            end
            bsc_pkg::S_READ: begin
                n_state = bsc_pkg::S_CMP;
            end
            bsc_pkg::S_CMP: begin
                n_state = i_stat.res_last ? bsc_pkg::S_ADD : bsc_pkg::S_READ;
            end
            bsc_pkg::S_ADD: begin
                n_state = bsc_pkg::S_NEXT;
            end
            bsc_pkg::S_NEXT: begin
                n_state = i_stat.sweep_last ? bsc_pkg::S_DONE : bsc_pkg::S_PROC;
            end
            bsc_pkg::S_DONE: begin
                n_state = bsc_pkg::S_EMIT;
            end
            bsc_pkg::S_EMIT: begin
                if (!i_out_stall && i_stat.out_last) begin
                    n_state = bsc_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = (r_state != bsc_pkg::S_IDLE);
        o_out_valid = (r_state == bsc_pkg::S_EMIT);
        unique case (r_state)
            bsc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (bsc_pkg::t_req'(i_req_type))
                        bsc_pkg::REQ_LOAD_ENTRY: o_cmd.wr_entry = 1'b1;
                        bsc_pkg::REQ_LOAD_AVAIL: o_cmd.wr_avail = 1'b1;
                        bsc_pkg::REQ_RUN:        o_cmd.init     = 1'b1;
                        default: ;
                    endcase
                end
            end
            bsc_pkg::S_PROC: begin
                o_cmd.start_proc = !i_stat.fin_cur;
            end
            bsc_pkg::S_READ: ;
            bsc_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
            end
            bsc_pkg::S_ADD: begin
                o_cmd.add = 1'b1;
            end
            bsc_pkg::S_NEXT: begin
                o_cmd.next_proc = 1'b1;
            end
            bsc_pkg::S_DONE: begin
                o_cmd.load_out = 1'b1;
            end
            bsc_pkg::S_EMIT: begin
                o_cmd.adv_out = !i_out_stall && !i_stat.out_last;
            end
        endcase
    end

endmodule

// ----- hdl/bsc_datapath.sv -----
module bsc_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [bsc_pkg::PROC_W-1:0]             i_proc_index,
    input  logic [bsc_pkg::RES_W-1:0]              i_res_index,
    input  logic [bsc_pkg::COUNT_BITS-1:0]         i_alloc_count,
    input  logic [bsc_pkg::COUNT_BITS-1:0]         i_max_count,
    input  logic [bsc_pkg::COUNT_BITS-1:0]         i_avail_count,
    input  bsc_pkg::t_cmd                          i_cmd,
    output bsc_pkg::t_stat                         o_stat,
    output logic                                   o_is_safe,
    output logic [bsc_pkg::PROC_W-1:0]             o_seq_proc,
    output logic                                   o_last
);

    logic [bsc_pkg::NUMP_W-1:0]     r_num_procs;
    logic [bsc_pkg::NUMR_W-1:0]     r_num_res;

    logic [bsc_pkg::COUNT_BITS-1:0] r_alloc_mem [bsc_pkg::DEPTH];
    logic [bsc_pkg::NEED_W-1:0]     r_need_mem  [bsc_pkg::DEPTH];
    logic [bsc_pkg::COUNT_BITS-1:0] r_alloc_q;
    logic [bsc_pkg::NEED_W-1:0]     r_need_q;

    logic [bsc_pkg::COUNT_BITS-1:0] r_avail [bsc_pkg::MAX_RES];
    logic [bsc_pkg::WORK_W-1:0]     r_work  [bsc_pkg::MAX_RES];
    logic [bsc_pkg::COUNT_BITS-1:0] r_tmp   [bsc_pkg::MAX_RES];
    logic [bsc_pkg::MAX_PROCS-1:0]  r_fin;
    logic [bsc_pkg::PROC_W-1:0]     r_seq   [bsc_pkg::MAX_PROCS];
    logic [bsc_pkg::PCNT_W-1:0]     r_len;

    logic [bsc_pkg::PROC_W-1:0]     r_i;
    logic [bsc_pkg::PROC_W-1:0]     r_k;
    logic [bsc_pkg::RES_W-1:0]      r_j;
    logic                           r_fit;
    logic [bsc_pkg::PROC_W-1:0]     r_oi;

    logic [bsc_pkg::PCNT_W-1:0]     w_np;
    logic [bsc_pkg::RCNT_W-1:0]     w_nr;
    logic [bsc_pkg::PROC_W-1:0]     w_np_m1;
    logic [bsc_pkg::RES_W-1:0]      w_nr_m1;
    logic [bsc_pkg::ADDR_W-1:0]     w_wr_addr;
    logic [bsc_pkg::ADDR_W-1:0]     w_rd_addr;
    logic [bsc_pkg::NEED_W-1:0]     w_need_in;
    logic signed [bsc_pkg::WORK_W:0] w_need_x;
    logic signed [bsc_pkg::WORK_W:0] w_work_x;
    logic                           w_lane_ok;
    logic [bsc_pkg::PROC_W-1:0]     w_oi_nx;

    always_comb begin
        if (r_num_procs == '0) begin
            w_np = bsc_pkg::PCNT_W'(1);
        end else if (32'(r_num_procs) > bsc_pkg::MAX_PROCS) begin
            w_np = bsc_pkg::PCNT_W'(bsc_pkg::MAX_PROCS);
        end else begin
            w_np = bsc_pkg::PCNT_W'(r_num_procs);
        end
        if (r_num_res == '0) begin
            w_nr = bsc_pkg::RCNT_W'(1);
        end else if (32'(r_num_res) > bsc_pkg::MAX_RES) begin
            w_nr = bsc_pkg::RCNT_W'(bsc_pkg::MAX_RES);
        end else begin
            w_nr = bsc_pkg::RCNT_W'(r_num_res);
        end
    end

    assign w_np_m1   = bsc_pkg::PROC_W'(w_np - bsc_pkg::PCNT_W'(1));
    assign w_nr_m1   = bsc_pkg::RES_W'(w_nr - bsc_pkg::RCNT_W'(1));
    assign w_wr_addr = {i_proc_index, i_res_index};
    assign w_rd_addr = {r_i, r_j};
    assign w_need_in = {1'b0, i_max_count} - {1'b0, i_alloc_count};
    assign w_need_x  = $signed({{(bsc_pkg::WORK_W + 1 - bsc_pkg::NEED_W){r_need_q[bsc_pkg::NEED_W-1]}},
                                r_need_q});
    assign w_work_x  = $signed({1'b0, r_work[r_j]});
    assign w_lane_ok = !(w_need_x > w_work_x);
    assign w_oi_nx   = r_oi + bsc_pkg::PROC_W'(1);

    assign o_stat.fin_cur    = r_fin[r_i];
    assign o_stat.res_last   = (r_j == w_nr_m1);
    assign o_stat.sweep_last = (r_i == w_np_m1) && (r_k == w_np_m1);
    assign o_stat.out_last   = o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= bsc_pkg::NUMP_W'(16);
            r_num_res   <= bsc_pkg::NUMR_W'(8);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bsc_pkg::CFG_NUM_PROCS) begin
                r_num_procs <= i_cfg_data[bsc_pkg::NUMP_W-1:0];
            end else if (i_cfg_idx == bsc_pkg::CFG_NUM_RES) begin
                r_num_res <= i_cfg_data[bsc_pkg::NUMR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_alloc_mem[w_wr_addr] <= i_alloc_count;
            r_need_mem[w_wr_addr]  <= w_need_in;
        end
        r_alloc_q <= r_alloc_mem[w_rd_addr];
        r_need_q  <= r_need_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_avail) begin
            r_avail[i_res_index] <= i_avail_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < bsc_pkg::MAX_RES; l++) begin
            if (i_cmd.init) begin
                if (bsc_pkg::RES_W'(l) <= w_nr_m1) begin
                    r_work[l] <= bsc_pkg::WORK_W'(r_avail[l]);
                end else begin
                    r_work[l] <= '0;
                end
            end else if (i_cmd.add && r_fit && bsc_pkg::RES_W'(l) <= w_nr_m1) begin
                r_work[l] <= r_work[l] + bsc_pkg::WORK_W'(r_tmp[l]);
            end
        end
        if (i_cmd.cmp) begin
            r_tmp[r_j] <= r_alloc_q;
        end
        if (i_cmd.add && r_fit) begin
            r_seq[r_len[bsc_pkg::PROC_W-1:0]] <= r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0;
            r_len <= '0;
            r_i   <= '0;
            r_k   <= '0;
            r_j   <= '0;
            r_fit <= 1'b0;
            r_oi  <= '0;
        end else begin
            if (i_cmd.init) begin
                r_fin <= '0;
                r_len <= '0;
                r_i   <= '0;
                r_k   <= '0;
            end
            if (i_cmd.start_proc) begin
                r_j   <= '0;
                r_fit <= 1'b1;
            end
            if (i_cmd.cmp) begin
                r_fit <= r_fit & w_lane_ok;
                r_j   <= r_j + bsc_pkg::RES_W'(1);
            end
            if (i_cmd.add && r_fit) begin
                r_fin[r_i] <= 1'b1;
                r_len      <= r_len + bsc_pkg::PCNT_W'(1);
            end
            if (i_cmd.next_proc) begin
                if (r_i == w_np_m1) begin
                    r_i <= '0;
                    r_k <= r_k + bsc_pkg::PROC_W'(1);
                end else begin
                    r_i <= r_i + bsc_pkg::PROC_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_oi <= '0;
            end else if (i_cmd.adv_out) begin
                r_oi <= w_oi_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_len == w_np) begin
                o_is_safe  <= 1'b1;
                o_seq_proc <= r_seq[0];
                o_last     <= (w_np_m1 == '0);
            end else begin
                o_is_safe  <= 1'b0;
                o_seq_proc <= '0;
                o_last     <= 1'b1;
            end
        end else if (i_cmd.adv_out) begin
            o_seq_proc <= r_seq[w_oi_nx];
            o_last     <= (w_oi_nx == w_np_m1);
        end
    end

endmodule

// ----- hdl/bankers_safety_check.sv -----
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   req_type, proc_index, res_index, counts
// out       output     o_out_valid / i_out_stall is_safe, seq_proc, last
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Load items are accepted only while idle. A run takes np passes of np process slots; a
// finished slot is skipped, else each resource is read through a registered read of the
// need/alloc memories and compared; a fitting slot is added. The result is loaded last.
// Results go out one per cycle while the output is not stalled; no input is taken
// from the run item until the last result of the run is accepted.
// Reset is synchronous, active low; the stores hold no reset value.
`include "assert_macros.svh"

module bankers_safety_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [bsc_pkg::PROC_W-1:0]          i_proc_index,
    input  logic [bsc_pkg::RES_W-1:0]           i_res_index,
    input  logic [bsc_pkg::COUNT_BITS-1:0]      i_alloc_count,
    input  logic [bsc_pkg::COUNT_BITS-1:0]      i_max_count,
    input  logic [bsc_pkg::COUNT_BITS-1:0]      i_avail_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_is_safe,
    output logic [bsc_pkg::PROC_W-1:0]          o_seq_proc,
    output logic                                o_last
);

    bsc_pkg::t_cmd  w_cmd;
    bsc_pkg::t_stat w_stat;

    bsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    bsc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_proc_index  (i_proc_index),
        .i_res_index   (i_res_index),
        .i_alloc_count (i_alloc_count),
        .i_max_count   (i_max_count),
        .i_avail_count (i_avail_count),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_is_safe     (o_is_safe),
        .o_seq_proc    (o_seq_proc),
        .o_last        (o_last)
    );

    `ASSERT_IMPL(a_busy_while_emit, i_clk, i_rst_n, o_out_valid, o_in_stall, "input taken while emitting")
    `ASSERT_IMPL(a_unsafe_is_last, i_clk, i_rst_n, o_out_valid && !o_is_safe, o_last, "unsafe item not last")
    `ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_last, !o_out_valid && !o_in_stall, "no return to idle after last item")
    `ASSERT_NEXT(a_run_goes_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_req_type == bsc_pkg::REQ_RUN, o_in_stall, "run item did not start a run")

endmodule
